// File: rtl/lpds_pkg.sv
// Shared types and constants for the LED PWM driver serializer.
`default_nettype none

package lpds_pkg;

    // Storage sizing
    localparam int unsigned MAX_CHANNELS = 16;
    localparam int unsigned MAX_CHIPS    = 8;
    localparam int unsigned STORE_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CHNUM_W  = 4;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned CHIP_W   = 4;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned CFGIDX_W = 3;
    localparam int unsigned CFGDAT_W = 16;

    // Stream widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = CMD_W;
    localparam int unsigned M_TDATA_W = 8;

    // Latch pulse counts and byte length
    localparam logic [CNT_W-1:0] PULSES_INIT_A = CNT_W'(12);
    localparam logic [CNT_W-1:0] PULSES_INIT_B = CNT_W'(16);
    localparam logic [CNT_W-1:0] PULSES_FRAME  = CNT_W'(8);
    localparam logic [CNT_W-1:0] BYTE_BITS     = CNT_W'(8);

    // Grayscale depths and the matching command bytes
    localparam logic [CNT_W-1:0] DEPTH_8  = CNT_W'(8);
    localparam logic [CNT_W-1:0] DEPTH_12 = CNT_W'(12);
    localparam logic [CNT_W-1:0] DEPTH_14 = CNT_W'(14);
    localparam logic [CNT_W-1:0] DEPTH_16 = CNT_W'(16);
    localparam logic [DUTY_W-1:0] WCODE_8  = DUTY_W'(3 << 3);
    localparam logic [DUTY_W-1:0] WCODE_12 = DUTY_W'(2 << 3);
    localparam logic [DUTY_W-1:0] WCODE_14 = DUTY_W'(1 << 3);
    localparam logic [DUTY_W-1:0] WCODE_16 = DUTY_W'(0 << 3);

    // Register reset values
    localparam logic [CNT_W-1:0]   RST_CHANNELS = CNT_W'(6);
    localparam logic [CHIP_W-1:0]  RST_CHIPS    = CHIP_W'(2);
    localparam logic [CNT_W-1:0]   RST_DEPTH    = CNT_W'(16);
    localparam logic [DELAY_W-1:0] RST_DELAY    = DELAY_W'(12);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_INIT = 2'd2
    } cmd_t;

    typedef enum logic [CFGIDX_W-1:0] {
        CFG_CHANNEL_COUNT  = 3'd0,
        CFG_CHIP_COUNT     = 3'd1,
        CFG_DEPTH_REQUEST  = 3'd2,
        CFG_DELAY_TICKS    = 3'd3,
        CFG_INITIAL_UPDATE = 3'd4
    } cfg_idx_t;

    // Configuration as seen by the sequencer (counts already clamped)
    typedef struct packed {
        logic [CNT_W-1:0]   eff_channels;
        logic [CHIP_W-1:0]  eff_chips;
        logic [CNT_W-1:0]   depth_request;
        logic [DELAY_W-1:0] delay_ticks;
        logic               initial_update;
    } cfg_t;

    // One result item, data_pin in bit 0
    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic clock_pin;
        logic data_pin;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/led_pwm_driver_serializer_unit.sv
// Top level of the LED PWM driver serializer.
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   tuser: cmd; tdata: channel_number, duty_value
// m_        out        m_tvalid / m_tready   tdata: data_pin, clock_pin, busy_res, rejected
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every command transfer is executed in the cycle it is taken: one result per
// transfer, registered in a two-entry output buffer, so a new command may be
// taken every cycle while the buffer has room, and each result is offered on m_ from it.
// s_tready drops only while both buffer entries wait on m_tready.
// aresetn is synchronous: sequencer idle, duty slots zero, registers to defaults.
// cfg_ready is always high; a write lands on the next edge.

module led_pwm_driver_serializer_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // stream in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lpds_pkg::S_TDATA_W-1:0]  s_tdata,  // [3:0] channel_number,
                                                           // [19:4] duty_value, [23:20] zero
    input  wire logic [lpds_pkg::S_TUSER_W-1:0]  s_tuser,  // [1:0] cmd
    // stream out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lpds_pkg::M_TDATA_W-1:0]       m_tdata,  // [0] data_pin, [1] clock_pin,
                                                           // [2] busy_res, [3] rejected
    // register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lpds_pkg::CFGIDX_W-1:0]   cfg_index,
    input  wire logic [lpds_pkg::CFGDAT_W-1:0]   cfg_data
);
    import lpds_pkg::*;

    cfg_t cfg;
    res_t core_res;
    res_t out_res;
    logic item_valid;

    // command transfer
    assign item_valid = s_tvalid & s_tready;

    lpds_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpds_seq_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (item_valid),
        .cmd            (s_tuser[CMD_W-1:0]),
        .channel_number (s_tdata[CHNUM_W-1:0]),
        .duty_value     (s_tdata[CHNUM_W +: DUTY_W]),
        .cfg            (cfg),
        .res            (core_res)
    );

    lpds_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .in_ready  (s_tready),
        .in_res    (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // result bits low, zero fill up to the byte
    assign m_tdata = M_TDATA_W'(out_res);

endmodule

`default_nettype wire

// File: rtl/lpds_cfg_regs.sv
// Configuration register bank with clamped channel and chip counts.
`default_nettype none

module lpds_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lpds_pkg::CFGIDX_W-1:0]  cfg_index,
    input  wire logic [lpds_pkg::CFGDAT_W-1:0]  cfg_data,
    output lpds_pkg::cfg_t                      cfg
);
    import lpds_pkg::*;

    logic [CNT_W-1:0]   chan_count_reg;
    logic [CHIP_W-1:0]  chip_count_reg;
    logic [CNT_W-1:0]   depth_req_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               init_upd_reg;
    logic               wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_count_reg <= RST_CHANNELS;
            chip_count_reg <= RST_CHIPS;
            depth_req_reg  <= RST_DEPTH;
            delay_reg      <= RST_DELAY;
            init_upd_reg   <= 1'b1;
        end else if (wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CHANNEL_COUNT:  chan_count_reg <= cfg_data[CNT_W-1:0];
                CFG_CHIP_COUNT:     chip_count_reg <= cfg_data[CHIP_W-1:0];
                CFG_DEPTH_REQUEST:  depth_req_reg  <= cfg_data[CNT_W-1:0];
                CFG_DELAY_TICKS:    delay_reg      <= cfg_data[DELAY_W-1:0];
                CFG_INITIAL_UPDATE: init_upd_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.eff_channels   = (chan_count_reg > CNT_W'(MAX_CHANNELS)) ?
                             CNT_W'(MAX_CHANNELS) : chan_count_reg;
        cfg.eff_chips      = (chip_count_reg > CHIP_W'(MAX_CHIPS)) ?
                             CHIP_W'(MAX_CHIPS) : chip_count_reg;
        cfg.depth_request  = depth_req_reg;
        cfg.delay_ticks    = delay_reg;
        cfg.initial_update = init_upd_reg;
    end

endmodule

`default_nettype wire

// File: rtl/lpds_seq_core.sv
// Pin sequencer: duty store, phase state and the one-step update per item.
`default_nettype none

module lpds_seq_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    input  wire logic [lpds_pkg::CMD_W-1:0]    cmd,
    input  wire logic [lpds_pkg::CHNUM_W-1:0]  channel_number,
    input  wire logic [lpds_pkg::DUTY_W-1:0]   duty_value,
    input  lpds_pkg::cfg_t                     cfg,
    output lpds_pkg::res_t                     res
);
    import lpds_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_IDLY1  = 4'd1,
        PH_IPUL12 = 4'd2,
        PH_IDLY2  = 4'd3,
        PH_IBYTES = 4'd4,
        PH_IDLY3  = 4'd5,
        PH_IPUL16 = 4'd6,
        PH_FWORDS = 4'd7,
        PH_FDLY   = 4'd8,
        PH_FPUL8  = 4'd9
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [CNT_W-1:0]   bit_cnt;
        logic [CNT_W-1:0]   word_cnt;
        logic [CNT_W-1:0]   pulse_cnt;
        logic [DELAY_W-1:0] wait_cnt;
        logic [DUTY_W-1:0]  shift;
        logic               data;
        logic               clk;
    } seq_t;

    function automatic logic is_delay(phase_t p);
        return (p == PH_IDLY1) || (p == PH_IDLY2) || (p == PH_IDLY3) || (p == PH_FDLY);
    endfunction

    function automatic logic [DUTY_W-1:0] width_code(logic [CNT_W-1:0] d);
        logic [DUTY_W-1:0] w;
        priority if (d <= DEPTH_8)  w = WCODE_8;
        else if (d <= DEPTH_12)     w = WCODE_12;
        else if (d <= DEPTH_14)     w = WCODE_14;
        else                        w = WCODE_16;
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] round_depth(logic [CNT_W-1:0] d);
        logic [CNT_W-1:0] r;
        priority if (d <= DEPTH_8)  r = DEPTH_8;
        else if (d <= DEPTH_12)     r = DEPTH_12;
        else if (d <= DEPTH_14)     r = DEPTH_14;
        else                        r = DEPTH_16;
        return r;
    endfunction

    // The closing pulse bursts end the sequence; every other phase hands over to the next phase.
    function automatic phase_t next_of(phase_t p);
        phase_t q;
        if ((p == PH_IPUL16) || (p == PH_FPUL8)) q = PH_IDLE;
        else                                     q = phase_t'(4'(p + 4'd1));
        return q;
    endfunction

    // Skip empty phases (zero delay, zero chips, zero channels).
    function automatic phase_t resolve(phase_t p, cfg_t c);
        phase_t q;
        q = p;
        for (int i = 0; i < 4; i++) begin
            if (is_delay(q) && (c.delay_ticks == '0))
                q = phase_t'(4'(q + 4'd1));
            else if ((q == PH_IBYTES) && (c.eff_chips == '0))
                q = PH_IDLY3;
            else if ((q == PH_FWORDS) && (c.eff_channels == '0))
                q = PH_FDLY;
        end
        return q;
    endfunction

    function automatic seq_t enter(seq_t s, phase_t p, cfg_t c, logic [CNT_W-1:0] depth,
                                   logic [DUTY_W-1:0] word);
        seq_t   r;
        phase_t q;
        r = s;
        q = resolve(p, c);
        r.phase = q;
        unique case (q)
            PH_IDLY1, PH_IDLY2, PH_IDLY3, PH_FDLY: r.wait_cnt = c.delay_ticks;
            PH_IPUL12: begin
                r.pulse_cnt = PULSES_INIT_A;
                r.bit_cnt   = '0;
            end
            PH_IPUL16: begin
                r.pulse_cnt = PULSES_INIT_B;
                r.bit_cnt   = '0;
            end
            PH_FPUL8: begin
                r.pulse_cnt = PULSES_FRAME;
                r.bit_cnt   = '0;
            end
            PH_IBYTES: begin
                r.word_cnt = CNT_W'(c.eff_chips);
                r.shift    = width_code(depth);
                r.bit_cnt  = BYTE_BITS;
            end
            PH_FWORDS: begin
                r.word_cnt = '0;
                r.shift    = word;
                r.bit_cnt  = depth;
            end
            default: r.phase = PH_IDLE;
        endcase
        return r;
    endfunction

    function automatic seq_t advance(seq_t s, cfg_t c, logic [CNT_W-1:0] depth,
                                     logic [DUTY_W-1:0] word);
        seq_t               r;
        logic [CNT_W-1:0]   nb;
        logic [CNT_W-1:0]   nw;
        logic [CNT_W-1:0]   np;
        logic [DELAY_W-1:0] nwait;
        r     = s;
        nb    = s.bit_cnt - CNT_W'(1);
        np    = s.pulse_cnt - CNT_W'(1);
        nwait = s.wait_cnt - DELAY_W'(1);
        nw    = s.word_cnt;
        unique case (s.phase)
            PH_IDLY1, PH_IDLY2, PH_IDLY3, PH_FDLY: begin
                r.wait_cnt = nwait;
                if (nwait == '0) r = enter(r, next_of(s.phase), c, depth, word);
            end
            PH_IPUL12, PH_IPUL16, PH_FPUL8: begin
                if (s.bit_cnt == '0) begin
                    r.data    = 1'b1;
                    r.bit_cnt = CNT_W'(1);
                end else begin
                    r.data      = 1'b0;
                    r.bit_cnt   = '0;
                    r.pulse_cnt = np;
                    if (np == '0) r = enter(r, next_of(s.phase), c, depth, word);
                end
            end
            PH_IBYTES: begin
                r.bit_cnt = nb;
                r.data    = s.shift[nb[3:0]];
                r.clk     = ~s.clk;
                if (nb == '0) begin
                    nw         = s.word_cnt - CNT_W'(1);
                    r.word_cnt = nw;
                    if (nw == '0) r = enter(r, PH_IDLY3, c, depth, word);
                    else          r.bit_cnt = BYTE_BITS;
                end
            end
            PH_FWORDS: begin
                r.bit_cnt = nb;
                r.data    = s.shift[nb[3:0]];
                r.clk     = ~s.clk;
                if (nb == '0) begin
                    nw         = s.word_cnt + CNT_W'(1);
                    r.word_cnt = nw;
                    if (nw >= c.eff_channels) begin
                        r = enter(r, PH_FDLY, c, depth, word);
                    end else begin
                        r.shift   = word;
                        r.bit_cnt = depth;
                    end
                end
            end
            default: r.phase = PH_IDLE;
        endcase
        return r;
    endfunction

    logic [DUTY_W-1:0]   duty_store_reg [MAX_CHANNELS];
    seq_t                seq_reg, seq_next;
    logic                dirty_reg, dirty_next;
    logic [CNT_W-1:0]    depth_reg, depth_next;
    cmd_t                cmd_e;
    logic [STORE_AW-1:0] set_idx;
    logic [STORE_AW-1:0] rd_addr;
    logic [DUTY_W-1:0]   rd_data;
    logic                set_ok;
    logic                store_we;
    logic                rejected;

    assign cmd_e   = cmd_t'(cmd);
    assign set_ok  = CNT_W'(channel_number) < cfg.eff_channels;
    assign set_idx = STORE_AW'(cfg.eff_channels - CNT_W'(1) - CNT_W'(channel_number));

    // Single read port: set compares at its slot, a tick loads the next word
    // (slot 0 when a frame starts).
    always_comb begin
        if (cmd_e == CMD_SET)             rd_addr = set_idx;
        else if (seq_reg.phase == PH_IDLE) rd_addr = '0;
        else                               rd_addr = STORE_AW'(seq_reg.word_cnt + CNT_W'(1));
    end

    assign rd_data = duty_store_reg[rd_addr];

    always_comb begin
        seq_next   = seq_reg;
        dirty_next = dirty_reg;
        depth_next = depth_reg;
        store_we   = 1'b0;
        rejected   = 1'b0;
        if (item_valid) begin
            unique case (cmd_e)
                CMD_TICK: begin
                    if (seq_reg.phase != PH_IDLE) begin
                        seq_next = advance(seq_reg, cfg, depth_reg, rd_data);
                    end else if (dirty_reg) begin
                        dirty_next = 1'b0;
                        seq_next   = advance(enter(seq_reg, PH_FWORDS, cfg, depth_reg, rd_data),
                                             cfg, depth_reg, rd_data);
                    end
                end
                CMD_SET: begin
                    if (!set_ok) begin
                        rejected = 1'b1;
                    end else begin
                        store_we = 1'b1;
                        if (rd_data != duty_value) dirty_next = 1'b1;
                    end
                end
                CMD_INIT: begin
                    depth_next = round_depth(cfg.depth_request);
                    dirty_next = cfg.initial_update;
                    seq_next   = enter(seq_reg, PH_IDLY1, cfg, depth_reg, rd_data);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res.data_pin  = seq_next.data;
        res.clock_pin = seq_next.clk;
        res.busy_res  = seq_next.phase != PH_IDLE;
        res.rejected  = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= '{phase: PH_IDLE, default: '0};
            dirty_reg <= 1'b0;
            depth_reg <= DEPTH_16;
        end else begin
            seq_reg   <= seq_next;
            dirty_reg <= dirty_next;
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) duty_store_reg[i] <= '0;
        end else if (store_we) begin
            duty_store_reg[set_idx] <= duty_value;
        end
    end

    // Half a latch pulse is tracked in bit_cnt
    a_pulse_half: assert property (@(posedge aclk) disable iff (!aresetn)
        ((seq_reg.phase == PH_IPUL12) || (seq_reg.phase == PH_IPUL16) ||
         (seq_reg.phase == PH_FPUL8)) |-> (seq_reg.bit_cnt <= CNT_W'(1)))
        else $error("pulse phase with bit count above one");

    a_shift_left: assert property (@(posedge aclk) disable iff (!aresetn)
        ((seq_reg.phase == PH_IBYTES) || (seq_reg.phase == PH_FWORDS)) |->
        (seq_reg.bit_cnt != '0))
        else $error("shift phase holds an exhausted word");

    a_delay_live: assert property (@(posedge aclk) disable iff (!aresetn)
        is_delay(seq_reg.phase) |-> (seq_reg.wait_cnt != '0))
        else $error("delay phase with zero wait count");

    a_depth_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (depth_reg == DEPTH_8) || (depth_reg == DEPTH_12) ||
        (depth_reg == DEPTH_14) || (depth_reg == DEPTH_16))
        else $error("depth in use is not a supported width");

    a_init_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn && item_valid && (cmd_e == CMD_INIT)) |-> (seq_reg.phase != PH_IDLE))
        else $error("init did not start a sequence");

endmodule

`default_nettype wire

// File: rtl/lpds_out_skid.sv
// Two-entry result buffer between the sequencer and the output stream.
`default_nettype none

module lpds_out_skid (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  lpds_pkg::res_t in_res,
    output logic           out_valid,
    input  wire logic      out_ready,
    output lpds_pkg::res_t out_res
);
    import lpds_pkg::*;

    res_t       buf_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_res   = buf_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= in_res;
    end

endmodule

`default_nettype wire

// File: tb/led_pwm_driver_serializer_unit_test.sv
// Self-checking testbench for the LED PWM driver serializer: directed table, then random episodes.
module led_pwm_driver_serializer_unit_test;
    import lpds_pkg::*;

    // Command code the block must ignore
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // Length of the long receiver hold-off, in clock cycles
    localparam int HOLD_CYCLES = 60;
    // Upper bound on ticks spent waiting for one sequence to wind down
    localparam int SETTLE_CAP = 400;

    // Sequencer phases as the predictor tracks them
    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_IDLY1, SEQ_IPUL12, SEQ_IDLY2, SEQ_IBYTES,
        SEQ_IDLY3, SEQ_IPUL16, SEQ_FWORDS, SEQ_FDLY, SEQ_FPUL8
    } seq_t;

    // One row of the directed table; levels only count where typed is set
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHNUM_W-1:0] chan;
        logic [DUTY_W-1:0]  duty;
        logic               typed;
        res_t               levels;  // {rejected, busy_res, clock_pin, data_pin}
    } row_t;

    // Register settings for one phase of the run, plus how many transfers it offers
    typedef struct packed {
        logic [CNT_W-1:0]   channels;
        logic [CHIP_W-1:0]  chips;
        logic [CNT_W-1:0]   depth;
        logic [DELAY_W-1:0] delay;
        logic               refresh;
        logic [15:0]        budget;
    } plan_t;

    // Directed part, run on the reset settings (6 channels, 2 chips, depth 16, delay 12).
    // Channel c lands in slot 5 - c, and slot 0 is the first word shifted out.
    localparam row_t DIRECTED [22] = '{
        '{CMD_TICK,   4'd0,  16'h0000, 1'b1, 4'b0000},  // idle and clean: nothing moves
        '{CMD_UNUSED, 4'd9,  16'hFFFF, 1'b1, 4'b0000},  // unused code ignored
        '{CMD_SET,    4'd15, 16'hFFFF, 1'b1, 4'b1000},  // top channel, out of range
        '{CMD_SET,    4'd6,  16'h1234, 1'b1, 4'b1000},  // first channel past the count
        '{CMD_SET,    4'd5,  16'h0000, 1'b1, 4'b0000},  // same value: store stays clean
        '{CMD_TICK,   4'd0,  16'h0000, 1'b1, 4'b0000},  // still clean, no frame
        '{CMD_SET,    4'd0,  16'hFFFF, 1'b1, 4'b0000},
        '{CMD_SET,    4'd5,  16'h0001, 1'b1, 4'b0000},
        '{CMD_SET,    4'd2,  16'hA5C3, 1'b0, 4'b0000},
        '{CMD_TICK,   4'd0,  16'h0000, 1'b1, 4'b0110},  // frame starts: msb of 0x0001, clock up
        '{CMD_SET,    4'd1,  16'h7FFF, 1'b0, 4'b0000},  // set while busy
        '{CMD_TICK,   4'd0,  16'h0000, 1'b0, 4'b0000},
        '{CMD_TICK,   4'd3,  16'hFFFF, 1'b0, 4'b0000},
        '{CMD_UNUSED, 4'd0,  16'h0000, 1'b0, 4'b0000},  // unused code while busy
        '{CMD_INIT,   4'd0,  16'h0000, 1'b0, 4'b0000},  // init drops the running frame
        '{CMD_TICK,   4'd0,  16'h0000, 1'b0, 4'b0000},
        '{CMD_INIT,   4'd15, 16'hFFFF, 1'b0, 4'b0000},  // init restarted mid init
        '{CMD_TICK,   4'd0,  16'h0000, 1'b0, 4'b0000},
        '{CMD_TICK,   4'd0,  16'h0000, 1'b0, 4'b0000},
        '{CMD_SET,    4'd3,  16'h8000, 1'b0, 4'b0000},
        '{CMD_TICK,   4'd0,  16'h0000, 1'b0, 4'b0000},
        '{CMD_TICK,   4'd0,  16'h0000, 1'b0, 4'b0000}
    };

    // Fixed phases: extremes first, then ordinary mixes. Random phases follow.
    localparam plan_t FIXED_PLAN [7] = '{
        '{5'd1,  4'd1,  5'd0,  16'd0,     1'b1, 16'd80},   // depth 0 rounds to 8, no delays
        '{5'd16, 4'd8,  5'd16, 16'd3,     1'b0, 16'd400},  // full store, full chain
        '{5'd0,  4'd0,  5'd8,  16'd5,     1'b1, 16'd60},   // no channels, no chips
        '{5'd31, 4'd15, 5'd31, 16'd1,     1'b1, 16'd100},  // counts above the maximum
        '{5'd6,  4'd2,  5'd12, 16'd65535, 1'b1, 16'd60},   // longest delay
        '{5'd3,  4'd3,  5'd14, 16'd2,     1'b1, 16'd100},
        '{5'd2,  4'd1,  5'd9,  16'd0,     1'b0, 16'd100}   // depth 9 rounds to 12
    };
    localparam int RANDOM_PHASES = 4;

    // Idle modes, chosen by phase number modulo 4
    int gap_by_mode   [4] = '{0, 56, 0, 15};
    int stall_by_mode [4] = '{0, 0, 56, 15};

    string field_names [4] = '{"data_pin", "clock_pin", "busy_res", "rejected"};

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFGIDX_W-1:0]  cfg_index;
    logic [CFGDAT_W-1:0]  cfg_data;

    led_pwm_driver_serializer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Expected pin levels, oldest first
    res_t pin_levels_due [$];
    int   mismatches = 0;
    int   items_sent = 0;

    // Set by the sender beside each transfer; typed rows override the prediction
    logic row_typed;
    res_t row_levels;

    // Idling controls, written by the stimulus process
    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;

    // ------------------------------------------------------------------
    // Predictor: register copy and sequencer state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   reg_channels;
    logic [CHIP_W-1:0]  reg_chips;
    logic [CNT_W-1:0]   reg_depth;
    logic [DELAY_W-1:0] reg_delay;
    logic               reg_refresh;

    logic [DUTY_W-1:0]  duty_slots [MAX_CHANNELS];
    logic               refresh_due;
    seq_t               seq_phase;
    logic [CNT_W-1:0]   bits_left;
    logic [CNT_W-1:0]   word_idx;
    logic [CNT_W-1:0]   pulses_left;
    logic [DELAY_W-1:0] wait_left;
    logic [DUTY_W-1:0]  shifter;
    logic               data_lv;
    logic               clock_lv;
    logic [CNT_W-1:0]   depth_now;

    function automatic void clear_model();
        reg_channels = RST_CHANNELS;
        reg_chips    = RST_CHIPS;
        reg_depth    = RST_DEPTH;
        reg_delay    = RST_DELAY;
        reg_refresh  = 1'b1;
        foreach (duty_slots[i]) duty_slots[i] = '0;
        refresh_due = 1'b0;
        seq_phase   = SEQ_IDLE;
        bits_left   = '0;
        word_idx    = '0;
        pulses_left = '0;
        wait_left   = '0;
        shifter     = '0;
        data_lv     = 1'b0;
        clock_lv    = 1'b0;
        depth_now   = DEPTH_16;
    endfunction

    function automatic logic [CNT_W-1:0] live_channels();
        return (reg_channels > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : reg_channels;
    endfunction

    function automatic logic [CHIP_W-1:0] live_chips();
        return (reg_chips > MAX_CHIPS) ? CHIP_W'(MAX_CHIPS) : reg_chips;
    endfunction

    function automatic logic [DUTY_W-1:0] width_byte();
        if (depth_now <= DEPTH_8) return WCODE_8;
        if (depth_now <= DEPTH_12) return WCODE_12;
        if (depth_now <= DEPTH_14) return WCODE_14;
        return WCODE_16;
    endfunction

    function automatic void load_slot();
        shifter   = (word_idx < MAX_CHANNELS) ? duty_slots[word_idx[STORE_AW-1:0]] : '0;
        bits_left = depth_now;
    endfunction

    // Enter a phase, falling through any that have nothing to do
    function automatic void start_phase(seq_t p);
        seq_t q = p;
        bit   settled = 1'b0;
        while (!settled) begin
            settled = 1'b1;
            case (q)
                SEQ_IDLY1, SEQ_IDLY2, SEQ_IDLY3, SEQ_FDLY: begin
                    if (reg_delay == '0) begin
                        q = seq_t'(q + 1);
                        settled = 1'b0;
                    end else begin
                        wait_left = reg_delay;
                    end
                end
                SEQ_IPUL12: begin
                    pulses_left = PULSES_INIT_A;
                    bits_left   = '0;
                end
                SEQ_IPUL16: begin
                    pulses_left = PULSES_INIT_B;
                    bits_left   = '0;
                end
                SEQ_FPUL8: begin
                    pulses_left = PULSES_FRAME;
                    bits_left   = '0;
                end
                SEQ_IBYTES: begin
                    if (live_chips() == '0) begin
                        q = SEQ_IDLY3;
                        settled = 1'b0;
                    end else begin
                        word_idx  = CNT_W'(live_chips());
                        shifter   = width_byte();
                        bits_left = BYTE_BITS;
                    end
                end
                SEQ_FWORDS: begin
                    if (live_channels() == '0) begin
                        q = SEQ_FDLY;
                        settled = 1'b0;
                    end else begin
                        word_idx = '0;
                        load_slot();
                    end
                end
                default: q = SEQ_IDLE;
            endcase
        end
        seq_phase = q;
    endfunction

    function automatic seq_t after_phase(seq_t p);
        return (p == SEQ_IPUL16 || p == SEQ_FPUL8) ? SEQ_IDLE : seq_t'(p + 1);
    endfunction

    // One data bit: msb first, clock line toggles
    function automatic void shift_out_bit();
        bits_left = bits_left - 1'b1;
        data_lv   = shifter[bits_left[3:0]];
        clock_lv  = ~clock_lv;
    endfunction

    // One tick of a running sequence
    function automatic void step_sequence();
        seq_t p = seq_phase;
        case (p)
            SEQ_IDLY1, SEQ_IDLY2, SEQ_IDLY3, SEQ_FDLY: begin
                wait_left = wait_left - 1'b1;
                if (wait_left == '0) start_phase(after_phase(p));
            end
            SEQ_IPUL12, SEQ_IPUL16, SEQ_FPUL8: begin
                // latch pulse: data high for a tick, then low for a tick
                if (bits_left == '0) begin
                    data_lv   = 1'b1;
                    bits_left = 5'd1;
                end else begin
                    data_lv     = 1'b0;
                    bits_left   = '0;
                    pulses_left = pulses_left - 1'b1;
                    if (pulses_left == '0) start_phase(after_phase(p));
                end
            end
            SEQ_IBYTES: begin
                shift_out_bit();
                if (bits_left == '0) begin
                    word_idx = word_idx - 1'b1;
                    if (word_idx == '0) start_phase(SEQ_IDLY3);
                    else bits_left = BYTE_BITS;
                end
            end
            SEQ_FWORDS: begin
                shift_out_bit();
                if (bits_left == '0) begin
                    word_idx = word_idx + 1'b1;
                    // count compared after every word, so a shrunk count ends early
                    if (word_idx >= live_channels()) start_phase(SEQ_FDLY);
                    else load_slot();
                end
            end
            default: seq_phase = SEQ_IDLE;
        endcase
    endfunction

    // Levels expected after one command transfer
    function automatic res_t predict_levels(logic [CMD_W-1:0] cmd, logic [CHNUM_W-1:0] chan,
                                            logic [DUTY_W-1:0] duty);
        logic             rej = 1'b0;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] slot;
        res_t             r;
        case (cmd)
            CMD_TICK: begin
                if (seq_phase == SEQ_IDLE) begin
                    if (refresh_due) begin
                        // frame starts and takes its first step on this tick
                        refresh_due = 1'b0;
                        start_phase(SEQ_FWORDS);
                        if (seq_phase != SEQ_IDLE) step_sequence();
                    end
                end else begin
                    step_sequence();
                end
            end
            CMD_SET: begin
                n = live_channels();
                if ({1'b0, chan} >= n) begin
                    rej = 1'b1;
                end else begin
                    slot = n - 5'd1 - {1'b0, chan};
                    if (duty_slots[slot[STORE_AW-1:0]] != duty) refresh_due = 1'b1;
                    duty_slots[slot[STORE_AW-1:0]] = duty;
                end
            end
            CMD_INIT: begin
                if (reg_depth <= DEPTH_8) depth_now = DEPTH_8;
                else if (reg_depth <= DEPTH_12) depth_now = DEPTH_12;
                else if (reg_depth <= DEPTH_14) depth_now = DEPTH_14;
                else depth_now = DEPTH_16;
                refresh_due = reg_refresh;
                start_phase(SEQ_IDLY1);
            end
            default: ;
        endcase
        r.rejected  = rej;
        r.busy_res  = (seq_phase != SEQ_IDLE);
        r.clock_pin = clock_lv;
        r.data_pin  = data_lv;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog, receiver
    // ------------------------------------------------------------------
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog: ends the run as a failure if it has not finished
    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls per mode, long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: register writes and commands feed the predictor, results checked
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_transfers
        res_t want;
        res_t got;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CHANNEL_COUNT:  reg_channels = cfg_data[CNT_W-1:0];
                    CFG_CHIP_COUNT:     reg_chips    = cfg_data[CHIP_W-1:0];
                    CFG_DEPTH_REQUEST:  reg_depth    = cfg_data[CNT_W-1:0];
                    CFG_DELAY_TICKS:    reg_delay    = cfg_data[DELAY_W-1:0];
                    CFG_INITIAL_UPDATE: reg_refresh  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = predict_levels(s_tuser, s_tdata[CHNUM_W-1:0],
                                      s_tdata[CHNUM_W +: DUTY_W]);
                if (row_typed) want = row_levels;
                pin_levels_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[3:0]);
                if (pin_levels_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %b", $time, got);
                    mismatches++;
                end else begin
                    want = pin_levels_due.pop_front();
                    for (int f = 0; f < 4; f++) begin
                        if (got[f] !== want[f]) begin
                            $display("%0t: %s expected %b got %b", $time, field_names[f],
                                     want[f], got[f]);
                            mismatches++;
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one command and wait for its transfer; random gaps ahead of it
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [CHNUM_W-1:0] chan,
                             logic [DUTY_W-1:0] duty, logic typed, res_t levels);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid   = 1'b1;
        s_tuser    = cmd;
        s_tdata    = {4'h0, duty, chan};
        row_typed  = typed;
        row_levels = levels;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pin_levels_due.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFGDAT_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [DUTY_W-1:0] pick_duty();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return DUTY_W'($urandom());
        endcase
    endfunction

    // Mostly in-range channels; sometimes rewrites the stored value unchanged
    task automatic send_random_set();
        logic [CNT_W-1:0]   n;
        logic [CNT_W-1:0]   slot;
        logic [CHNUM_W-1:0] chan;
        logic [DUTY_W-1:0]  duty;
        n = live_channels();
        if (n != '0 && $urandom_range(99) < 85) chan = CHNUM_W'($urandom_range(n - 1));
        else chan = CHNUM_W'($urandom_range(15));
        duty = pick_duty();
        if ({1'b0, chan} < n && $urandom_range(9) == 0) begin
            slot = n - 5'd1 - {1'b0, chan};
            duty = duty_slots[slot[STORE_AW-1:0]];
        end
        send_item(CMD_SET, chan, duty, 1'b0, '0);
    endtask

    // Ticks (with the odd set) until the sequencer is idle and clean
    task automatic settle(int start, int budget);
        int n = 0;
        do begin
            if ($urandom_range(99) < 8) send_random_set();
            else send_item(CMD_TICK, CHNUM_W'($urandom_range(15)), pick_duty(), 1'b0, '0);
            n++;
        end while (!(seq_phase == SEQ_IDLE && !refresh_due) && n < SETTLE_CAP &&
                   items_sent - start < budget);
    endtask

    // Random episodes: init and run it out, update a few slots and run the
    // frame out, or a short burst of noise. First episode is always an init.
    task automatic run_phase(int budget, int hold_at, int pause_at);
        int start = items_sent;
        int kind;
        bit first = 1'b1;
        bit held = 1'b0;
        bit paused = 1'b0;
        while (items_sent - start < budget) begin
            kind = first ? 0 : int'($urandom_range(99));
            first = 1'b0;
            if (kind < 10) begin
                send_item(CMD_INIT, CHNUM_W'($urandom_range(15)), pick_duty(), 1'b0, '0);
                settle(start, budget);
            end else if (kind < 70) begin
                repeat ($urandom_range(4, 1)) send_random_set();
                settle(start, budget);
            end else begin
                // random command codes, unused code included
                repeat ($urandom_range(12, 1))
                    send_item(CMD_W'($urandom_range(3)), CHNUM_W'($urandom_range(15)),
                              pick_duty(), 1'b0, '0);
            end
            // long receiver hold-off while transfers keep coming
            if (hold_at > 0 && !held && items_sent - start >= hold_at) begin
                hold_requests++;
                held = 1'b1;
            end
            // sender waits for every result before going on
            if (pause_at > 0 && !paused && items_sent - start >= pause_at) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        plan_t plan;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_TICK;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_CHANNEL_COUNT;
        cfg_data   = '0;
        row_typed  = 1'b0;
        row_levels = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table on the reset settings, no idling
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].cmd, DIRECTED[i].chan, DIRECTED[i].duty,
                      DIRECTED[i].typed, DIRECTED[i].levels);
        run_phase(60, 30, 0);

        for (int ph = 1; ph <= 7 + RANDOM_PHASES; ph++) begin
            // registers change only once every result is in
            drain_results();
            repeat (4) @(negedge aclk);
            if (ph <= 7) begin
                plan = FIXED_PLAN[ph - 1];
            end else begin
                plan.channels = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(31))
                                                        : CNT_W'($urandom_range(6));
                plan.chips    = CHIP_W'($urandom_range(15));
                plan.depth    = CNT_W'($urandom_range(31));
                plan.delay    = DELAY_W'($urandom_range(6));
                plan.refresh  = 1'($urandom_range(1));
                plan.budget   = 16'd80;
            end
            write_reg(CFG_CHANNEL_COUNT, CFGDAT_W'(plan.channels));
            write_reg(CFG_CHIP_COUNT, CFGDAT_W'(plan.chips));
            write_reg(CFG_DEPTH_REQUEST, CFGDAT_W'(plan.depth));
            write_reg(CFG_DELAY_TICKS, plan.delay);
            write_reg(CFG_INITIAL_UPDATE, CFGDAT_W'(plan.refresh));
            gap_pct   = gap_by_mode[ph % 4];
            stall_pct = stall_by_mode[ph % 4];
            run_phase(int'(plan.budget), (ph == 4) ? 40 : 0, (ph == 2) ? 150 : 0);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pin_levels_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/lpds_pkg.sv
rtl/lpds_cfg_regs.sv
rtl/lpds_seq_core.sv
rtl/lpds_out_skid.sv
rtl/led_pwm_driver_serializer_unit.sv
tb/led_pwm_driver_serializer_unit_test.sv
